// ===== sv/cau_pkg.sv =====
// shared types and constants for the complex arithmetic unit
package cau_pkg;

  // width of every operand and result field on the ports
  localparam int FIELD_W = 32;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  // per-item control that travels with the data behind the front end
  // index 0 is the real part, index 1 the imaginary part
  typedef struct packed {
    logic       is_div;
    logic       dz;
    logic [1:0] neg;
    logic [1:0] ovf;
  } ctl_t;

endpackage

// ===== sv/complex_arithmetic_unit.sv =====
// complex add/subtract/multiply/divide on fixed-point operands, fully pipelined
// throughput: one item per cycle unless out_ready holds the pipe; every operation runs the same pipe, so order holds
// the divider takes one quotient bit per stage, which sets the depth of the pipe
// ready ripples back stage by stage, so bubbles close up while a result waits
// reset (rst_n low, synchronous) clears only the stage valid bits
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_action,
  input  logic [cau_pkg::FIELD_W-1:0] in_a_real,
  input  logic [cau_pkg::FIELD_W-1:0] in_a_imag,
  input  logic [cau_pkg::FIELD_W-1:0] in_b_real,
  input  logic [cau_pkg::FIELD_W-1:0] in_b_imag,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cau_pkg::FIELD_W-1:0] out_res_real,
  output logic [cau_pkg::FIELD_W-1:0] out_res_imag,
  output logic                        out_overflow,
  output logic                        out_div_by_zero
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;

  // links between the front end, the DW divider steps and the output stage;
  // link 0 leaves the front end, link DW enters the output stage
  logic [DW:0]        vld_c;
  logic [DW:0]        rdy_c;
  cau_pkg::ctl_t      ctl_c [DW+1];
  logic [PW-1:0]      den_c [DW+1];
  logic [1:0][PW-1:0] rem_c [DW+1];
  logic [1:0][DW-1:0] low_c [DW+1];
  logic [1:0][DW-1:0] quo_c [DW+1];

  // six stages: unpack and add/sub, products, signed terms, numerators,
  // magnitudes, scaling plus range check and divider seed
  cau_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_a_real  (in_a_real),
    .in_a_imag  (in_a_imag),
    .in_b_real  (in_b_real),
    .in_b_imag  (in_b_imag),
    .down_valid (vld_c[0]),
    .down_ready (rdy_c[0]),
    .ctl_o      (ctl_c[0]),
    .den_o      (den_c[0]),
    .rem_o      (rem_c[0]),
    .low_o      (low_c[0]),
    .quo_o      (quo_c[0])
  );

  // restoring division, real and imaginary side by side against one divisor;
  // non-divide items pass through these stages untouched
  for (genvar g = 0; g < DW; g++) begin : g_div
    cau_div_stage #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_valid   (vld_c[g]),
      .up_ready   (rdy_c[g]),
      .ctl_i      (ctl_c[g]),
      .den_i      (den_c[g]),
      .rem_i      (rem_c[g]),
      .low_i      (low_c[g]),
      .quo_i      (quo_c[g]),
      .down_valid (vld_c[g+1]),
      .down_ready (rdy_c[g+1]),
      .ctl_o      (ctl_c[g+1]),
      .den_o      (den_c[g+1]),
      .rem_o      (rem_c[g+1]),
      .low_o      (low_c[g+1]),
      .quo_o      (quo_c[g+1])
    );
  end

  // clamp to the signed range, restore sign, zero on a zero divisor;
  // its register is the output register
  cau_sat #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_sat (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (vld_c[DW]),
    .up_ready        (rdy_c[DW]),
    .ctl_i           (ctl_c[DW]),
    .quo_i           (quo_c[DW]),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_res_real    (out_res_real),
    .out_res_imag    (out_res_imag),
    .out_overflow    (out_overflow),
    .out_div_by_zero (out_div_by_zero)
  );

endmodule

// ===== sv/cau_front.sv =====
// front end: operand unpack, products, sums, magnitude and range check
module cau_front #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_action,
  input  logic [cau_pkg::FIELD_W-1:0]       in_a_real,
  input  logic [cau_pkg::FIELD_W-1:0]       in_a_imag,
  input  logic [cau_pkg::FIELD_W-1:0]       in_b_real,
  input  logic [cau_pkg::FIELD_W-1:0]       in_b_imag,
  output logic                              down_valid,
  input  logic                              down_ready,
  output cau_pkg::ctl_t                     ctl_o,
  output logic [2*DATA_WIDTH-1:0]           den_o,
  output logic [1:0][2*DATA_WIDTH-1:0]      rem_o,
  output logic [1:0][DATA_WIDTH-1:0]        low_o,
  output logic [1:0][DATA_WIDTH-1:0]        quo_o
);

  localparam int DW   = DATA_WIDTH;
  localparam int PW   = 2 * DW;
  localparam int NW   = PW + 1;
  localparam int SW   = PW + FRAC_BITS;
  localparam int FW   = cau_pkg::FIELD_W;
  localparam int NSTG = 6;
  localparam int T_RR = 0;
  localparam int T_II = 1;
  localparam int T_RI = 2;
  localparam int T_IR = 3;

  // stage valid bits and ready chain
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] vin;

  assign vin        = {vld_r[NSTG-2:0], in_valid};
  assign in_ready   = rdy[0];
  assign down_valid = vld_r[NSTG-1];

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || down_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vin[k];
        end
      end
    end
  end

  // operands at DW bits
  logic [1:0][DW-1:0] av;
  logic [1:0][DW-1:0] bv;

  if (DW <= FW) begin : g_narrow
    assign av[0] = in_a_real[DW-1:0];
    assign av[1] = in_a_imag[DW-1:0];
    assign bv[0] = in_b_real[DW-1:0];
    assign bv[1] = in_b_imag[DW-1:0];
  end else begin : g_wide
    assign av[0] = {{(DW-FW){1'b0}}, in_a_real};
    assign av[1] = {{(DW-FW){1'b0}}, in_a_imag};
    assign bv[0] = {{(DW-FW){1'b0}}, in_b_real};
    assign bv[1] = {{(DW-FW){1'b0}}, in_b_imag};
  end

  // stage 1: sign-magnitude split, add/subtract
  cau_pkg::action_t   act_in;
  logic [1:0]         sa_nxt, sb_nxt;
  logic [1:0][DW-1:0] ma_nxt, mb_nxt;
  logic [1:0][DW:0]   sum_nxt;

  cau_pkg::action_t   act1_r;
  logic [1:0]         sa1_r, sb1_r;
  logic [1:0][DW-1:0] ma1_r, mb1_r;
  logic [1:0][DW:0]   sum1_r;

  assign act_in = cau_pkg::action_t'(in_action);

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sa_nxt[k] = av[k][DW-1];
      sb_nxt[k] = bv[k][DW-1];
      ma_nxt[k] = sa_nxt[k] ? -av[k] : av[k];
      mb_nxt[k] = sb_nxt[k] ? -bv[k] : bv[k];
      if (act_in == cau_pkg::ACT_SUB) begin
        sum_nxt[k] = {av[k][DW-1], av[k]} - {bv[k][DW-1], bv[k]};
      end else begin
        sum_nxt[k] = {av[k][DW-1], av[k]} + {bv[k][DW-1], bv[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      act1_r <= act_in;
      sa1_r  <= sa_nxt;
      sb1_r  <= sb_nxt;
      ma1_r  <= ma_nxt;
      mb1_r  <= mb_nxt;
      sum1_r <= sum_nxt;
    end
  end

  // stage 2: cross products and divisor squares
  logic [3:0][PW-1:0] pt_nxt;
  logic [3:0]         ps_nxt;
  logic [1:0][PW-1:0] sq_nxt;

  cau_pkg::action_t   act2_r;
  logic [3:0][PW-1:0] pt2_r;
  logic [3:0]         ps2_r;
  logic [1:0][PW-1:0] sq2_r;
  logic [1:0][DW:0]   sum2_r;

  always_comb begin
    pt_nxt[T_RR] = PW'(ma1_r[0]) * PW'(mb1_r[0]);
    pt_nxt[T_II] = PW'(ma1_r[1]) * PW'(mb1_r[1]);
    pt_nxt[T_RI] = PW'(ma1_r[0]) * PW'(mb1_r[1]);
    pt_nxt[T_IR] = PW'(ma1_r[1]) * PW'(mb1_r[0]);
    ps_nxt[T_RR] = sa1_r[0] ^ sb1_r[0];
    ps_nxt[T_II] = sa1_r[1] ^ sb1_r[1];
    ps_nxt[T_RI] = sa1_r[0] ^ sb1_r[1];
    ps_nxt[T_IR] = sa1_r[1] ^ sb1_r[0];
    sq_nxt[0]    = PW'(mb1_r[0]) * PW'(mb1_r[0]);
    sq_nxt[1]    = PW'(mb1_r[1]) * PW'(mb1_r[1]);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      act2_r <= act1_r;
      pt2_r  <= pt_nxt;
      ps2_r  <= ps_nxt;
      sq2_r  <= sq_nxt;
      sum2_r <= sum1_r;
    end
  end

  // stage 3: signed terms, divisor magnitude squared
  logic [3:0][NW-1:0] t_nxt;
  logic [PW-1:0]      den3_nxt;

  cau_pkg::action_t   act3_r;
  logic [3:0][NW-1:0] t3_r;
  logic [PW-1:0]      den3_r;
  logic [1:0][DW:0]   sum3_r;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      t_nxt[j] = ps2_r[j] ? -{1'b0, pt2_r[j]} : {1'b0, pt2_r[j]};
    end
    den3_nxt = sq2_r[0] + sq2_r[1];
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      act3_r <= act2_r;
      t3_r   <= t_nxt;
      den3_r <= den3_nxt;
      sum3_r <= sum2_r;
    end
  end

  // stage 4: exact result numerators per operation
  logic [1:0][NW-1:0] num_nxt;

  cau_pkg::action_t   act4_r;
  logic [1:0][NW-1:0] num4_r;
  logic [PW-1:0]      den4_r;

  always_comb begin
    case (act3_r)
      cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
        num_nxt[0] = {{(NW-DW-1){sum3_r[0][DW]}}, sum3_r[0]};
        num_nxt[1] = {{(NW-DW-1){sum3_r[1][DW]}}, sum3_r[1]};
      end
      cau_pkg::ACT_MUL: begin
        num_nxt[0] = t3_r[T_RR] - t3_r[T_II];
        num_nxt[1] = t3_r[T_RI] + t3_r[T_IR];
      end
      cau_pkg::ACT_DIV: begin
        num_nxt[0] = t3_r[T_RR] + t3_r[T_II];
        num_nxt[1] = t3_r[T_IR] - t3_r[T_RI];
      end
      default: begin
        num_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      act4_r <= act3_r;
      num4_r <= num_nxt;
      den4_r <= den3_r;
    end
  end

  // stage 5: sign and magnitude, zero divisor detect
  logic [NW-1:0]      negv;
  logic [1:0]         neg_nxt;
  logic [1:0][PW-1:0] mag_nxt;
  logic               dz_nxt;

  cau_pkg::action_t   act5_r;
  logic [1:0]         neg5_r;
  logic [1:0][PW-1:0] mag5_r;
  logic               dz5_r;
  logic [PW-1:0]      den5_r;

  always_comb begin
    negv = '0;
    for (int k = 0; k < 2; k++) begin
      negv       = -num4_r[k];
      neg_nxt[k] = num4_r[k][NW-1];
      mag_nxt[k] = neg_nxt[k] ? negv[PW-1:0] : num4_r[k][PW-1:0];
    end
    dz_nxt = (act4_r == cau_pkg::ACT_DIV) && (den4_r == '0);
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      act5_r <= act4_r;
      neg5_r <= neg_nxt;
      mag5_r <= mag_nxt;
      dz5_r  <= dz_nxt;
      den5_r <= den4_r;
    end
  end

  // stage 6: scale, range check, divider seed
  logic [PW-1:0]      sm;
  logic [SW-1:0]      nsh;
  logic [SW-1:0]      hi;
  cau_pkg::ctl_t      ctl_nxt;
  logic [1:0][PW-1:0] rem_nxt;
  logic [1:0][DW-1:0] low_nxt;
  logic [1:0][DW-1:0] quo_nxt;

  cau_pkg::ctl_t      ctl6_r;
  logic [PW-1:0]      den6_r;
  logic [1:0][PW-1:0] rem6_r;
  logic [1:0][DW-1:0] low6_r;
  logic [1:0][DW-1:0] quo6_r;

  always_comb begin
    sm             = '0;
    nsh            = '0;
    hi             = '0;
    ctl_nxt.is_div = (act5_r == cau_pkg::ACT_DIV);
    ctl_nxt.dz     = dz5_r;
    ctl_nxt.neg    = neg5_r;
    ctl_nxt.ovf    = '0;
    for (int k = 0; k < 2; k++) begin
      sm  = (act5_r == cau_pkg::ACT_MUL) ? (mag5_r[k] >> FRAC_BITS) : mag5_r[k];
      nsh = SW'(mag5_r[k]) << FRAC_BITS;
      hi  = nsh >> DW;
      if (ctl_nxt.is_div) begin
        // quotient needs more than DW bits when the top part reaches the divisor
        ctl_nxt.ovf[k] = (hi >= SW'(den5_r));
        quo_nxt[k]     = '0;
      end else begin
        ctl_nxt.ovf[k] = |sm[PW-1:DW];
        quo_nxt[k]     = sm[DW-1:0];
      end
      rem_nxt[k] = hi[PW-1:0];
      low_nxt[k] = nsh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      ctl6_r <= ctl_nxt;
      den6_r <= den5_r;
      rem6_r <= rem_nxt;
      low6_r <= low_nxt;
      quo6_r <= quo_nxt;
    end
  end

  assign ctl_o = ctl6_r;
  assign den_o = den6_r;
  assign rem_o = rem6_r;
  assign low_o = low6_r;
  assign quo_o = quo6_r;

endmodule

// ===== sv/cau_div_stage.sv =====
// one restoring division step: one quotient bit per part
module cau_div_stage #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  cau_pkg::ctl_t                ctl_i,
  input  logic [2*DATA_WIDTH-1:0]      den_i,
  input  logic [1:0][2*DATA_WIDTH-1:0] rem_i,
  input  logic [1:0][DATA_WIDTH-1:0]   low_i,
  input  logic [1:0][DATA_WIDTH-1:0]   quo_i,
  output logic                         down_valid,
  input  logic                         down_ready,
  output cau_pkg::ctl_t                ctl_o,
  output logic [2*DATA_WIDTH-1:0]      den_o,
  output logic [1:0][2*DATA_WIDTH-1:0] rem_o,
  output logic [1:0][DATA_WIDTH-1:0]   low_o,
  output logic [1:0][DATA_WIDTH-1:0]   quo_o
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;

  logic               vld_r;
  cau_pkg::ctl_t      ctl_r;
  logic [PW-1:0]      den_r;
  logic [1:0][PW-1:0] rem_r;
  logic [1:0][DW-1:0] low_r;
  logic [1:0][DW-1:0] quo_r;

  logic [PW:0]        trial;
  logic [PW+1:0]      diff;
  logic               ge;
  logic [1:0][PW-1:0] rem_nxt;
  logic [1:0][DW-1:0] low_nxt;
  logic [1:0][DW-1:0] quo_nxt;

  assign up_ready   = !vld_r || down_ready;
  assign down_valid = vld_r;

  always_comb begin
    trial   = '0;
    diff    = '0;
    ge      = 1'b0;
    rem_nxt = rem_i;
    low_nxt = low_i;
    quo_nxt = quo_i;
    if (ctl_i.is_div) begin
      for (int k = 0; k < 2; k++) begin
        trial      = {rem_i[k], low_i[k][DW-1]};
        diff       = {1'b0, trial} - {2'b00, den_i};
        ge         = !diff[PW+1];
        rem_nxt[k] = ge ? diff[PW-1:0] : trial[PW-1:0];
        low_nxt[k] = {low_i[k][DW-2:0], 1'b0};
        quo_nxt[k] = {quo_i[k][DW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      ctl_r <= ctl_i;
      den_r <= den_i;
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign den_o = den_r;
  assign rem_o = rem_r;
  assign low_o = low_r;
  assign quo_o = quo_r;

endmodule

// ===== sv/cau_sat.sv =====
// saturation, sign restore and output register
module cau_sat #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  cau_pkg::ctl_t               ctl_i,
  input  logic [1:0][DATA_WIDTH-1:0]  quo_i,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cau_pkg::FIELD_W-1:0] out_res_real,
  output logic [cau_pkg::FIELD_W-1:0] out_res_imag,
  output logic                        out_overflow,
  output logic                        out_div_by_zero
);

  localparam int DW = DATA_WIDTH;
  localparam int FW = cau_pkg::FIELD_W;
  localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINN = {1'b1, {(DW-1){1'b0}}};

  logic [1:0]         over;
  logic [1:0][DW-1:0] val_nxt;

  logic               vld_r;
  logic [1:0][DW-1:0] val_r;
  logic               ovf_r;
  logic               dz_r;

  assign up_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (ctl_i.neg[k]) begin
        over[k]    = ctl_i.ovf[k] || (quo_i[k] > MINN);
        val_nxt[k] = over[k] ? MINN : -quo_i[k];
      end else begin
        over[k]    = ctl_i.ovf[k] || (quo_i[k] > MAXP);
        val_nxt[k] = over[k] ? MAXP : quo_i[k];
      end
      if (ctl_i.dz) begin
        over[k]    = 1'b0;
        val_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      val_r <= val_nxt;
      ovf_r <= |over;
      dz_r  <= ctl_i.dz;
    end
  end

  if (DW >= FW) begin : g_trunc
    assign out_res_real = val_r[0][FW-1:0];
    assign out_res_imag = val_r[1][FW-1:0];
  end else begin : g_sext
    assign out_res_real = {{(FW-DW){val_r[0][DW-1]}}, val_r[0]};
    assign out_res_imag = {{(FW-DW){val_r[1][DW-1]}}, val_r[1]};
  end

  assign out_overflow    = ovf_r;
  assign out_div_by_zero = dz_r;

endmodule

// ===== sim/complex_arithmetic_unit_tb.sv =====
// self-checking testbench for the pipelined complex arithmetic unit
module complex_arithmetic_unit_tb;

  localparam int DW          = 32;
  localparam int FRAC        = 16;
  // cycles with no transfer on either side before the run is declared hung
  localparam int IDLE_LIMIT  = 2000;
  // wait after the last result, so any straggling result still shows up
  localparam int TAIL_CYCLES = 60;

  localparam logic [31:0] FX_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] FX_MIN     = 32'h8000_0000;
  localparam logic [31:0] FX_ONE     = 32'h0001_0000;
  localparam logic [31:0] FX_NEG_ONE = 32'hffff_0000;
  localparam logic [31:0] FX_LSB_NEG = 32'hffff_ffff;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
    logic        dz;
  } cplx_result_t;

  // expected results in arrival order, computed with exact wide arithmetic
  class cau_scoreboard;
    cplx_result_t expected_results[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    // clamp to the signed 32-bit range, msb of the return is the saturation flag
    function logic [32:0] clamp(logic signed [127:0] v);
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = 128'sd2147483647;
      lo_lim = -128'sd2147483648;
      if (v > hi_lim) return {1'b1, FX_MAX};
      if (v < lo_lim) return {1'b1, FX_MIN};
      return {1'b0, v[31:0]};
    endfunction

    // signed division truncates toward zero, which is the rounding the block uses
    function cplx_result_t predict_complex(cau_pkg::action_t act, logic [31:0] ar_raw,
                                           logic [31:0] ai_raw, logic [31:0] br_raw,
                                           logic [31:0] bi_raw);
      logic signed [127:0] ar, ai, br, bi;
      logic signed [127:0] part_re, part_im, den, scale;
      logic [32:0]         cr, ci;
      cplx_result_t        r;
      ar = signed'(ar_raw);
      ai = signed'(ai_raw);
      br = signed'(br_raw);
      bi = signed'(bi_raw);
      scale = 128'sd1 <<< FRAC;
      r = '0;
      case (act)
        cau_pkg::ACT_ADD: begin
          part_re = ar + br;
          part_im = ai + bi;
        end
        cau_pkg::ACT_SUB: begin
          part_re = ar - br;
          part_im = ai - bi;
        end
        cau_pkg::ACT_MUL: begin
          part_re = (ar * br - ai * bi) / scale;
          part_im = (ar * bi + ai * br) / scale;
        end
        default: begin
          den = br * br + bi * bi;
          if (den == 0) begin
            r.dz = 1'b1;
            return r;
          end
          part_re = ((ar * br + ai * bi) * scale) / den;
          part_im = ((ai * br - ar * bi) * scale) / den;
        end
      endcase
      cr = clamp(part_re);
      ci = clamp(part_im);
      r.re  = cr[31:0];
      r.im  = ci[31:0];
      r.ovf = cr[32] | ci[32];
      return r;
    endfunction

    function void note_input(cau_pkg::action_t act, logic [31:0] ar, logic [31:0] ai,
                             logic [31:0] br, logic [31:0] bi);
      expected_results.push_back(predict_complex(act, ar, ai, br, bi));
    endfunction

    function void check_result(logic [31:0] re, logic [31:0] im, logic ovf, logic dz);
      cplx_result_t want;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing pending: res_real %h res_imag %h", re, im);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (re !== want.re) begin
        $error("res_real: expected %h, got %h", want.re, re);
        errors++;
      end
      if (im !== want.im) begin
        $error("res_imag: expected %h, got %h", want.im, im);
        errors++;
      end
      if (ovf !== want.ovf) begin
        $error("overflow: expected %b, got %b", want.ovf, ovf);
        errors++;
      end
      if (dz !== want.dz) begin
        $error("div_by_zero: expected %b, got %b", want.dz, dz);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action   = cau_pkg::ACT_ADD;
  logic [31:0] in_a_real   = '0;
  logic [31:0] in_a_imag   = '0;
  logic [31:0] in_b_real   = '0;
  logic [31:0] in_b_imag   = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [31:0] out_res_real;
  logic [31:0] out_res_imag;
  logic        out_overflow;
  logic        out_div_by_zero;

  cau_scoreboard sb = new();

  // when set, that side runs without idle cycles
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_stall  = 0;
  int idle_cycles = 0;

  complex_arithmetic_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_a_real      (in_a_real),
    .in_a_imag      (in_a_imag),
    .in_b_real      (in_b_real),
    .in_b_imag      (in_b_imag),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_res_real   (out_res_real),
    .out_res_imag   (out_res_imag),
    .out_overflow   (out_overflow),
    .out_div_by_zero(out_div_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle lengths: mostly none or short, now and then a long one
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // operand mix: corner values, full-range noise, and moderate Q16.16 values
  function automatic logic [31:0] rand_field();
    logic [31:0] mag;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: return '0;
          1: return 32'd1;
          2: return FX_LSB_NEG;
          3: return FX_MAX;
          4: return FX_MIN;
          5: return FX_ONE;
          default: return FX_NEG_ONE;
        endcase
      end
      1, 2, 3, 4: return $urandom();
      default: begin
        mag = $urandom_range(0, 32'h0010_0000);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  // one input transfer; valid is lowered only for an idle gap ahead of it
  task automatic send_item(cau_pkg::action_t act, logic [31:0] ar, logic [31:0] ai,
                           logic [31:0] br, logic [31:0] bi);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_a_real <= ar;
    in_a_imag <= ai;
    in_b_real <= br;
    in_b_imag <= bi;
    do @(posedge clk); while (!in_ready);
    sb.note_input(act, ar, ai, br, bi);
  endtask

  task automatic send_random(int count);
    cau_pkg::action_t act;
    logic [31:0]      ar, ai, br, bi;
    repeat (count) begin
      act = cau_pkg::action_t'($urandom_range(0, 3));
      ar  = rand_field();
      ai  = rand_field();
      br  = rand_field();
      bi  = rand_field();
      // make zero divisors a regular sight, not a one-in-billions event
      if (act == cau_pkg::ACT_DIV && $urandom_range(0, 19) == 0) begin
        br = '0;
        bi = '0;
      end
      send_item(act, ar, ai, br, bi);
    end
  endtask

  // sender holds off until the pipe has fully emptied
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // receiver back-pressure, one assignment of out_ready per edge
  always @(posedge clk) begin
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ready <= 1'b1;
      rx_stall = pick_gap(rx_steady);
    end
  end

  // result monitor samples pre-edge values
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_res_real, out_res_imag, out_overflow, out_div_by_zero);
  end

  // hang detector: any transfer on either side resets the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** complex_arithmetic_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // saturation on add and subtract, both directions
    send_item(cau_pkg::ACT_ADD, FX_MAX, FX_MAX, FX_MAX, FX_MAX);
    send_item(cau_pkg::ACT_ADD, FX_MIN, FX_MIN, FX_MIN, FX_MIN);
    send_item(cau_pkg::ACT_ADD, FX_ONE, FX_NEG_ONE, 32'h0002_0000, 32'h0000_8000);
    send_item(cau_pkg::ACT_SUB, FX_MIN, '0, FX_MAX, FX_MIN);
    send_item(cau_pkg::ACT_SUB, FX_MAX, FX_LSB_NEG, FX_LSB_NEG, FX_MAX);
    send_item(cau_pkg::ACT_SUB, '0, FX_ONE, '0, FX_ONE);
    // products: plain values, i*i, truncation of tiny negatives, saturation
    send_item(cau_pkg::ACT_MUL, 32'h0001_8000, '0, 32'h0002_0000, '0);
    send_item(cau_pkg::ACT_MUL, '0, FX_ONE, '0, FX_ONE);
    send_item(cau_pkg::ACT_MUL, FX_LSB_NEG, FX_LSB_NEG, 32'd1, '0);
    send_item(cau_pkg::ACT_MUL, FX_MIN, FX_MIN, FX_MIN, FX_MIN);
    send_item(cau_pkg::ACT_MUL, FX_MIN, '0, FX_MIN, '0);
    send_item(cau_pkg::ACT_MUL, FX_MAX, FX_MAX, FX_MAX, FX_MIN);
    // zero divisor with extreme and zero numerators
    send_item(cau_pkg::ACT_DIV, FX_MAX, FX_MIN, '0, '0);
    send_item(cau_pkg::ACT_DIV, '0, '0, '0, '0);
    // quotients: exact, truncated either sign, saturated, largest divisor
    send_item(cau_pkg::ACT_DIV, 32'h0003_0000, 32'h0004_0000, FX_ONE, 32'h0002_0000);
    send_item(cau_pkg::ACT_DIV, FX_ONE, '0, 32'h0003_0000, '0);
    send_item(cau_pkg::ACT_DIV, FX_NEG_ONE, '0, 32'h0003_0000, '0);
    send_item(cau_pkg::ACT_DIV, FX_MAX, FX_MAX, 32'd1, '0);
    send_item(cau_pkg::ACT_DIV, FX_MIN, FX_MIN, FX_MIN, FX_MIN);
    send_item(cau_pkg::ACT_DIV, 32'd1, '0, FX_MAX, FX_MAX);
    send_item(cau_pkg::ACT_DIV, FX_MIN, '0, FX_LSB_NEG, '0);
    send_item(cau_pkg::ACT_DIV, FX_MIN, FX_MAX, '0, FX_LSB_NEG);

    // random phases, each with its own idling mix; at least one phase with no idling
    for (int ph = 0; ph < 6; ph++) begin
      tx_steady = (ph == 1) || ($urandom_range(0, 3) == 0);
      rx_steady = (ph == 1) || ($urandom_range(0, 3) == 0);
      send_random(150);
      if (ph == 2) hold_until_drained();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** complex_arithmetic_unit: PASSED **");
    end else begin
      $display("** complex_arithmetic_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_div_stage.sv
sv/cau_sat.sv
sv/complex_arithmetic_unit.sv
sim/complex_arithmetic_unit_tb.sv
